[src/sewa_pkg.sv]
// Shared types and constants for the SII EEPROM word access sequencer.
package sewa_pkg;

    typedef logic [1:0] t_cfg_idx;
    typedef logic [15:0] t_cfg_data;

    localparam t_cfg_idx CFG_RETRY_LIMIT = 2'd0;
    localparam t_cfg_idx CFG_LOAD_TMO    = 2'd1;
    localparam t_cfg_idx CFG_BUSY_TMO    = 2'd2;
    localparam t_cfg_idx CFG_INHIBIT     = 2'd3;

    localparam logic [3:0]  RST_RETRY_LIMIT = 4'd3;
    localparam logic [15:0] RST_LOAD_TMO    = 16'd500;
    localparam logic [15:0] RST_BUSY_TMO    = 16'd20;
    localparam logic [15:0] RST_INHIBIT     = 16'd5;

    localparam logic [1:0] MODE_START_RD = 2'd0;
    localparam logic [1:0] MODE_START_WR = 2'd1;
    localparam logic [1:0] MODE_RESPONSE = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic [1:0] DGS_RECEIVED = 2'd0;
    localparam logic [1:0] DGS_TIMEOUT  = 2'd1;

    localparam logic [1:0] ACT_SEND   = 2'd0;
    localparam logic [1:0] ACT_DONE   = 2'd1;
    localparam logic [1:0] ACT_ERROR  = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    localparam logic [1:0] CMD_APWR = 2'd0;
    localparam logic [1:0] CMD_FPWR = 2'd1;
    localparam logic [1:0] CMD_APRD = 2'd2;
    localparam logic [1:0] CMD_FPRD = 2'd3;

    localparam logic [3:0] LEN_READ_REQ   = 4'd4;
    localparam logic [3:0] LEN_READ_CHECK = 4'd10;
    localparam logic [3:0] LEN_WRITE_REQ  = 4'd8;
    localparam logic [3:0] LEN_WRITE_CHK  = 4'd2;

    localparam logic [7:0] CTRL_READ  = 8'h80;
    localparam logic [7:0] CTRL_WRITE = 8'h81;
    localparam logic [7:0] CTRL_CHECK = 8'h00;

    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_CHECK = 2'd0;

    localparam logic [7:0] ST_ERROR     = 8'h20;
    localparam logic [7:0] ST_LOADING   = 8'h10;
    localparam logic [7:0] ST_RD_BUSY   = 8'h81;
    localparam logic [7:0] ST_WR_BUSY   = 8'h82;
    localparam logic [7:0] ST_WR_FAILED = 8'h40;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_RECV   = 3'd1;
    localparam logic [2:0] ERR_WC         = 3'd2;
    localparam logic [2:0] ERR_SII        = 3'd3;
    localparam logic [2:0] ERR_LOAD_TMO   = 3'd4;
    localparam logic [2:0] ERR_READ_TMO   = 3'd5;
    localparam logic [2:0] ERR_WRITE_TMO  = 3'd6;
    localparam logic [2:0] ERR_WRITE_FAIL = 3'd7;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  dg_command;
        logic [15:0] dg_address;
        logic [3:0]  dg_length;
        logic [7:0]  ctrl_byte;
        logic [1:0]  cmd_byte;
        logic [15:0] req_offset;
        logic [15:0] req_value;
        logic [31:0] read_value;
        logic [2:0]  error_code;
    } t_result;

    localparam t_result RESULT_IGNORE = '{
        action: ACT_IGNORE, dg_command: 2'd0, dg_address: 16'd0, dg_length: 4'd0,
        ctrl_byte: 8'd0, cmd_byte: 2'd0, req_offset: 16'd0, req_value: 16'd0,
        read_value: 32'd0, error_code: ERR_NONE
    };

endpackage

[src/sewa_req_if.sv]
// Request channel: start items and datagram responses into the sequencer.
interface sewa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] word_addr;
    logic [15:0] write_value;
    logic        addressing;
    logic [15:0] target_address;
    logic [1:0]  dg_status;
    logic [15:0] wkc;
    logic [7:0]  status_byte;
    logic [31:0] read_data;
    logic [15:0] sent_time_ms;
    logic [15:0] recv_time_ms;

    modport source (
        output valid, mode, word_addr, write_value, addressing, target_address,
        output dg_status, wkc, status_byte, read_data,
        output sent_time_ms, recv_time_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, word_addr, write_value, addressing, target_address,
        input  dg_status, wkc, status_byte, read_data,
        input  sent_time_ms, recv_time_ms,
        output ready
    );
endinterface

[src/sewa_rsp_if.sv]
// Result channel: datagram requests and completion status out of the sequencer.
interface sewa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  dg_command;
    logic [15:0] dg_address;
    logic [3:0]  dg_length;
    logic [7:0]  ctrl_byte;
    logic [1:0]  cmd_byte;
    logic [15:0] req_offset;
    logic [15:0] req_value;
    logic [31:0] read_value;
    logic [2:0]  error_code;

    modport source (
        output valid, action, dg_command, dg_address, dg_length, ctrl_byte,
        output cmd_byte, req_offset, req_value, read_value, error_code,
        input  ready
    );
    modport sink (
        input  valid, action, dg_command, dg_address, dg_length, ctrl_byte,
        input  cmd_byte, req_offset, req_value, read_value, error_code,
        output ready
    );
endinterface

[src/slave_eeprom_word_access_fsm.sv]
// Top level: SII EEPROM word access sequencer with config registers and result register.
//
//  channel   | dir | handshake           | carries
//  i_req     | in  | valid/ready         | start read/write or datagram response
//  o_rsp     | out | valid/ready         | request to send, done or error
//  i_cfg_*   | in  | write enable only   | retry limit, timeouts and write inhibit
//
// One transaction in gives one transaction out in the next cycle, through the result register.
// A new transaction is taken every cycle while the result register is empty or being drained.
// A stall on o_rsp holds the result register and drops i_req.ready until it is taken.
// Reset returns the sequencer to idle and loads the default retry limit, timeouts and write inhibit.
module slave_eeprom_word_access_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sewa_req_if.sink             i_req,
    sewa_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  sewa_pkg::t_cfg_idx   i_cfg_idx,
    input  sewa_pkg::t_cfg_data  i_cfg_data
);
    import sewa_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RD_REQ   = 3'd1;
    localparam logic [2:0] PH_RD_FETCH = 3'd2;
    localparam logic [2:0] PH_WR_REQ   = 3'd3;
    localparam logic [2:0] PH_WR_CHECK = 3'd4;

    logic [3:0]  r_retry_limit;
    logic [15:0] r_load_tmo, r_busy_tmo, r_inhibit;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_retries, n_retries;
    logic [15:0] r_start_time, n_start_time;
    logic        r_one_more, n_one_more;
    logic        r_loading_seen, n_loading_seen;
    logic [15:0] r_held_offset, n_held_offset;
    logic [15:0] r_held_value, n_held_value;
    logic        r_held_addr, n_held_addr;
    logic [15:0] r_held_target, n_held_target;

    t_result     r_out, n_out;
    logic        r_out_valid;
    logic        w_accept;
    logic [15:0] w_diff;

    function automatic t_result mk_req(input logic [1:0] cmd, input logic [3:0] len,
                                       input logic [7:0] ctrl, input logic [1:0] op,
                                       input logic [15:0] off, input logic [15:0] val,
                                       input logic [15:0] target);
        t_result res;
        res            = RESULT_IGNORE;
        res.action     = ACT_SEND;
        res.dg_command = cmd;
        res.dg_address = target;
        res.dg_length  = len;
        res.ctrl_byte  = ctrl;
        res.cmd_byte   = op;
        res.req_offset = off;
        res.req_value  = val;
        return res;
    endfunction

    function automatic t_result mk_end(input logic [1:0] act, input logic [31:0] data,
                                       input logic [2:0] code);
        t_result res;
        res            = RESULT_IGNORE;
        res.action     = act;
        res.read_value = data;
        res.error_code = code;
        return res;
    endfunction

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_diff      = i_req.recv_time_ms - r_start_time;

    always_comb begin
        t_result rd_req, rd_chk, wr_req, wr_chk;
        logic    is_rd_req, is_wr_req;
        logic    tmo_load, tmo_busy;

        n_phase        = r_phase;
        n_retries      = r_retries;
        n_start_time   = r_start_time;
        n_one_more     = r_one_more;
        n_loading_seen = r_loading_seen;
        n_held_offset  = r_held_offset;
        n_held_value   = r_held_value;
        n_held_addr    = r_held_addr;
        n_held_target  = r_held_target;
        n_out          = RESULT_IGNORE;

        is_rd_req = (i_req.mode == MODE_START_RD);
        is_wr_req = (i_req.mode == MODE_START_WR);
        if (is_rd_req || is_wr_req) begin
            n_held_offset = i_req.word_addr;
            n_held_value  = i_req.write_value;
            n_held_addr   = i_req.addressing;
            n_held_target = i_req.target_address;
        end

        rd_req = mk_req(n_held_addr ? CMD_FPWR : CMD_APWR, LEN_READ_REQ, CTRL_READ,
                        OP_READ, n_held_offset, 16'd0, n_held_target);
        rd_chk = mk_req(n_held_addr ? CMD_FPRD : CMD_APRD, LEN_READ_CHECK, CTRL_CHECK,
                        OP_CHECK, 16'd0, 16'd0, n_held_target);
        wr_req = mk_req(CMD_FPWR, LEN_WRITE_REQ, CTRL_WRITE, OP_WRITE, n_held_offset,
                        n_held_value, n_held_target);
        wr_chk = mk_req(CMD_FPRD, LEN_WRITE_CHK, CTRL_CHECK, OP_CHECK, 16'd0, 16'd0,
                        n_held_target);

        tmo_load = (w_diff >= r_load_tmo) && !r_one_more;
        tmo_busy = (w_diff >= r_busy_tmo) && !r_one_more;

        priority if (is_rd_req || is_wr_req) begin
            n_retries = r_retry_limit;
            n_out     = is_rd_req ? rd_req : wr_req;
            n_phase   = is_rd_req ? PH_RD_REQ : PH_WR_REQ;
        end else if (i_req.mode == MODE_UNUSED) begin
            n_out = RESULT_IGNORE;
        end else if (r_phase == PH_IDLE || r_phase > PH_WR_CHECK) begin
            n_out   = RESULT_IGNORE;
            n_phase = PH_IDLE;
        end else if (i_req.dg_status == DGS_TIMEOUT && r_retries != 4'd0) begin
            n_retries = r_retries - 4'd1;
            unique case (r_phase)
                PH_RD_REQ:   n_out = rd_req;
                PH_RD_FETCH: n_out = rd_chk;
                PH_WR_REQ:   n_out = wr_req;
                default:     n_out = wr_chk;
            endcase
        end else if (i_req.dg_status != DGS_RECEIVED) begin
            n_out   = mk_end(ACT_ERROR, 32'd0, ERR_NOT_RECV);
            n_phase = PH_IDLE;
        end else if (i_req.wkc != 16'd1) begin
            n_out   = mk_end(ACT_ERROR, 32'd0, ERR_WC);
            n_phase = PH_IDLE;
        end else if (r_phase == PH_RD_REQ || r_phase == PH_WR_REQ) begin
            n_start_time = i_req.sent_time_ms;
            n_one_more   = 1'b1;
            n_retries    = r_retry_limit;
            if (r_phase == PH_RD_REQ) begin
                n_loading_seen = 1'b0;
                n_out          = rd_chk;
                n_phase        = PH_RD_FETCH;
            end else begin
                n_out   = wr_chk;
                n_phase = PH_WR_CHECK;
            end
        end else if ((i_req.status_byte & ST_ERROR) != 8'd0) begin
            n_out   = mk_end(ACT_ERROR, 32'd0, ERR_SII);
            n_phase = PH_IDLE;
        end else if (r_phase == PH_RD_FETCH) begin
            priority if ((i_req.status_byte & ST_LOADING) != 8'd0) begin
                n_loading_seen = 1'b1;
                if (w_diff >= r_load_tmo) begin
                    n_one_more = 1'b0;
                end
                if (tmo_load) begin
                    n_out   = mk_end(ACT_ERROR, 32'd0, ERR_LOAD_TMO);
                    n_phase = PH_IDLE;
                end else begin
                    n_out     = rd_chk;
                    n_retries = r_retry_limit;
                end
            end else if (r_loading_seen) begin
                n_loading_seen = 1'b0;
                n_out          = rd_req;
                n_retries      = r_retry_limit;
                n_phase        = PH_RD_REQ;
            end else if ((i_req.status_byte & ST_RD_BUSY) != 8'd0) begin
                if (w_diff >= r_busy_tmo) begin
                    n_one_more = 1'b0;
                end
                if (tmo_busy) begin
                    n_out   = mk_end(ACT_ERROR, 32'd0, ERR_READ_TMO);
                    n_phase = PH_IDLE;
                end else begin
                    n_out     = rd_chk;
                    n_retries = r_retry_limit;
                end
            end else begin
                n_out   = mk_end(ACT_DONE, i_req.read_data, ERR_NONE);
                n_phase = PH_IDLE;
            end
        end else begin
            priority if (w_diff < r_inhibit) begin
                n_out     = wr_chk;
                n_retries = r_retry_limit;
            end else if ((i_req.status_byte & ST_WR_BUSY) != 8'd0) begin
                if (w_diff >= r_busy_tmo) begin
                    n_one_more = 1'b0;
                end
                if (tmo_busy) begin
                    n_out   = mk_end(ACT_ERROR, 32'd0, ERR_WRITE_TMO);
                    n_phase = PH_IDLE;
                end else begin
                    n_out     = wr_chk;
                    n_retries = r_retry_limit;
                end
            end else if ((i_req.status_byte & ST_WR_FAILED) != 8'd0) begin
                n_out   = mk_end(ACT_ERROR, 32'd0, ERR_WRITE_FAIL);
                n_phase = PH_IDLE;
            end else begin
                n_out   = mk_end(ACT_DONE, 32'd0, ERR_NONE);
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RST_RETRY_LIMIT;
            r_load_tmo    <= RST_LOAD_TMO;
            r_busy_tmo    <= RST_BUSY_TMO;
            r_inhibit     <= RST_INHIBIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[3:0];
                CFG_LOAD_TMO:    r_load_tmo    <= i_cfg_data;
                CFG_BUSY_TMO:    r_busy_tmo    <= i_cfg_data;
                CFG_INHIBIT:     r_inhibit     <= i_cfg_data;
                default:         r_retry_limit <= r_retry_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_retries      <= 4'd0;
            r_one_more     <= 1'b0;
            r_loading_seen <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase        <= n_phase;
                r_retries      <= n_retries;
                r_one_more     <= n_one_more;
                r_loading_seen <= n_loading_seen;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start_time  <= n_start_time;
            r_held_offset <= n_held_offset;
            r_held_value  <= n_held_value;
            r_held_addr   <= n_held_addr;
            r_held_target <= n_held_target;
            r_out         <= n_out;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.action     = r_out.action;
    assign o_rsp.dg_command = r_out.dg_command;
    assign o_rsp.dg_address = r_out.dg_address;
    assign o_rsp.dg_length  = r_out.dg_length;
    assign o_rsp.ctrl_byte  = r_out.ctrl_byte;
    assign o_rsp.cmd_byte   = r_out.cmd_byte;
    assign o_rsp.req_offset = r_out.req_offset;
    assign o_rsp.req_value  = r_out.req_value;
    assign o_rsp.read_value = r_out.read_value;
    assign o_rsp.error_code = r_out.error_code;

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (n_out.action == ACT_DONE || n_out.action == ACT_ERROR)
        |=> r_phase == PH_IDLE)
        else $error("sequencer not idle after finishing");

    a_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_WR_CHECK)
        else $error("phase out of range");

    a_data_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.action != ACT_DONE |-> r_out.read_value == 32'd0)
        else $error("read data outside a done result");

    a_request_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.action != ACT_SEND |-> r_out.dg_length == 4'd0)
        else $error("request fields set on a non-request result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |-> !w_accept)
        else $error("transaction taken while result register stalled");

endmodule
